// File: hdl/bqws_pkg.sv
package bqws_pkg;

    // lexer mode codes
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_ESCAPE    = 3'd1;
    localparam logic [2:0] MODE_QUOTE     = 3'd2;
    localparam logic [2:0] MODE_QUOTE_ESC = 3'd3;
    localparam logic [2:0] MODE_BRACE     = 3'd4;
    localparam logic [2:0] MODE_COMMENT   = 3'd6;

    // error codes reported with the end-of-text item
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OPEN     = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // one input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_item;

    // one result item
    typedef struct packed {
        logic [7:0] word_byte;
        logic       byte_valid;
        logic       word_end;
        logic       text_done;
        logic [1:0] error_code;
    } t_result;

    // escape decoding inside quotes
    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        logic [7:0] d;
        case (c)
            CH_LC_N: d = CH_LF;
            CH_LC_R: d = CH_CR;
            CH_LC_T: d = CH_TAB;
            CH_LC_E: d = CH_ESC;
            default: d = c;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/bqws_if.sv
interface bqws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bqws_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] word_byte;
    logic       byte_valid;
    logic       word_end;
    logic       text_done;
    logic [1:0] error_code;

    modport source (output valid, output word_byte, output byte_valid, output word_end,
                    output text_done, output error_code, input ready);
    modport sink   (input valid, input word_byte, input byte_valid, input word_end,
                    input text_done, input error_code, output ready);
endinterface

// File: hdl/brace_quote_word_splitter.sv
// brace_quote_word_splitter: splits script text into words, one byte per item
// a result passes through the input register and then the output register
// one item per cycle while the output is not stalled; the lexer step is combinational
// an item may be accepted while the previous result waits in the output register
// reset (synchronous, active low): pipeline emptied, lexer in normal mode,
// brace depth zero, comments enabled
module brace_quote_word_splitter
    import bqws_pkg::*;
#(
    parameter int MAX_BRACE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bqws_in_if.sink      i_in,
    bqws_out_if.source   o_out,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_data,
    output logic         o_cfg_ready
);

    logic    r_comments_en;
    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;

    logic    in_fire;
    logic    s1_go;
    logic    res_valid;
    t_result res;

    // handshake
    assign s1_go       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_go;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comments_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_comments_en <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.text_byte   <= i_in.text_byte;
            r_s1_item.end_of_text <= i_in.end_of_text;
        end
    end

    // lexer step
    bqws_lexer #(
        .MAX_BRACE_DEPTH(MAX_BRACE_DEPTH)
    ) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s1_go),
        .i_item       (r_s1_item),
        .i_comments_en(r_comments_en),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.word_byte  = r_out.word_byte;
    assign o_out.byte_valid = r_out.byte_valid;
    assign o_out.word_end   = r_out.word_end;
    assign o_out.text_done  = r_out.text_done;
    assign o_out.error_code = r_out.error_code;

endmodule

// File: hdl/bqws_lexer.sv
module bqws_lexer
    import bqws_pkg::*;
#(
    parameter int MAX_BRACE_DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  logic    i_comments_en,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int DW = $clog2(MAX_BRACE_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_BRACE_DEPTH);
    localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

    logic [2:0]    r_mode, n_mode;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_pending, n_pending;
    logic          r_overflow, n_overflow;

    logic [DW-1:0] depth_dec;
    logic [7:0]    c;

    assign c         = i_item.text_byte;
    assign depth_dec = (r_depth != '0) ? r_depth - DEPTH_ONE : r_depth;

    // one lexer step per item
    always_comb begin
        n_mode      = r_mode;
        n_depth     = r_depth;
        n_pending   = r_pending;
        n_overflow  = r_overflow;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_item.end_of_text) begin
            o_res_valid     = 1'b1;
            o_res.text_done = 1'b1;
            if (r_overflow) begin
                o_res.error_code = ERR_OVERFLOW;
            end else if (r_mode == MODE_ESCAPE || r_mode == MODE_QUOTE ||
                         r_mode == MODE_QUOTE_ESC || r_mode == MODE_BRACE) begin
                o_res.error_code = ERR_OPEN;
            end else begin
                o_res.word_end = r_pending;
            end
            n_mode     = MODE_NORMAL;
            n_depth    = '0;
            n_pending  = 1'b0;
            n_overflow = 1'b0;
        end else if (!r_overflow && c != CH_CR) begin
            unique case (r_mode)
                MODE_ESCAPE: begin
                    n_mode = MODE_NORMAL;
                    if (c == CH_LF) begin
                        o_res_valid    = r_pending;
                        o_res.word_end = r_pending;
                        n_pending      = 1'b0;
                    end else begin
                        n_pending        = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.word_byte  = c;
                        o_res.byte_valid = 1'b1;
                    end
                end
                MODE_QUOTE: begin
                    if (c == CH_DQUOTE) begin
                        o_res_valid = 1'b1;
                        if (r_depth == '0) begin
                            n_mode         = MODE_NORMAL;
                            o_res.word_end = 1'b1;
                        end else begin
                            n_mode           = MODE_BRACE;
                            o_res.word_byte  = c;
                            o_res.byte_valid = 1'b1;
                        end
                    end else if (c == CH_BSLASH) begin
                        n_mode = MODE_QUOTE_ESC;
                    end else begin
                        o_res_valid      = 1'b1;
                        o_res.word_byte  = c;
                        o_res.byte_valid = 1'b1;
                    end
                end
                MODE_QUOTE_ESC: begin
                    n_mode           = MODE_QUOTE;
                    o_res_valid      = 1'b1;
                    o_res.word_byte  = decode_escape(c);
                    o_res.byte_valid = 1'b1;
                end
                MODE_BRACE: begin
                    if (c == CH_RBRACE) begin
                        n_depth     = depth_dec;
                        o_res_valid = 1'b1;
                        if (depth_dec == '0) begin
                            n_mode         = MODE_NORMAL;
                            o_res.word_end = 1'b1;
                        end else begin
                            o_res.word_byte  = c;
                            o_res.byte_valid = 1'b1;
                        end
                    end else if (c == CH_LBRACE) begin
                        if (r_depth >= DEPTH_MAX) begin
                            n_overflow = 1'b1;
                        end else begin
                            n_depth          = r_depth + DEPTH_ONE;
                            o_res_valid      = 1'b1;
                            o_res.word_byte  = c;
                            o_res.byte_valid = 1'b1;
                        end
                    end else begin
                        if (c == CH_DQUOTE) begin
                            n_mode = MODE_QUOTE;
                        end
                        o_res_valid      = 1'b1;
                        o_res.word_byte  = c;
                        o_res.byte_valid = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                default: begin
                    // normal mode, unused codes fall here too
                    n_mode = MODE_NORMAL;
                    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_SEMI ||
                        c == CH_DQUOTE || c == CH_LBRACE ||
                        (c == CH_HASH && i_comments_en)) begin
                        // separators and openers end a pending word
                        o_res_valid    = r_pending;
                        o_res.word_end = r_pending;
                        n_pending      = 1'b0;
                        if (c == CH_DQUOTE) begin
                            n_mode  = MODE_QUOTE;
                            n_depth = '0;
                        end else if (c == CH_LBRACE) begin
                            n_mode  = MODE_BRACE;
                            n_depth = DEPTH_ONE;
                        end else if (c == CH_HASH) begin
                            n_mode = MODE_COMMENT;
                        end
                    end else if (c == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        n_pending        = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.word_byte  = c;
                        o_res.byte_valid = 1'b1;
                    end
                end
            endcase
        end
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NORMAL;
            r_depth    <= '0;
            r_pending  <= 1'b0;
            r_overflow <= 1'b0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_depth    <= n_depth;
            r_pending  <= n_pending;
            r_overflow <= n_overflow;
        end
    end

endmodule

// File: hdl/bqws_checker.sv
module bqws_checker
    import bqws_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_word_byte,
    input logic       i_byte_valid,
    input logic       i_word_end,
    input logic       i_text_done,
    input logic [1:0] i_error_code
);

    // an error drops the partial word
    a_err_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_error_code != ERR_NONE) |-> (i_text_done && !i_word_end))
        else $error("error code without end of text, or with a word end");

    // a byte and a word end never share one item
    a_byte_or_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_byte_valid && (i_word_end || i_text_done)))
        else $error("byte item also carries a word end or end of text");

    // no byte means the byte field reads zero
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_byte_valid) |-> (i_word_byte == 8'd0))
        else $error("word byte nonzero without byte valid");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_word_byte) && $stable(i_word_end) &&
             $stable(i_text_done) && $stable(i_error_code)))
        else $error("stalled result changed");

endmodule

bind brace_quote_word_splitter bqws_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_word_byte (o_out.word_byte),
    .i_byte_valid(o_out.byte_valid),
    .i_word_end  (o_out.word_end),
    .i_text_done (o_out.text_done),
    .i_error_code(o_out.error_code)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bqws_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int BRACE_LIMIT      = 16;
    localparam int DRAIN_CYCLES     = 6;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int PHASE_COUNT      = 5;
    localparam int RANDOM_PER_PHASE = 90;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic i_cfg_data;
    logic o_cfg_ready;

    bqws_in_if  in_if ();
    bqws_out_if out_if ();

    // script bytes waiting for the driver, and words the splitter should produce
    t_item   text_items[$];
    t_result expected_words[$];
    int      loaded_count;
    int      mismatches;

    // splitter state as predicted
    logic [2:0] lx_mode;
    int         lx_depth;
    logic       lx_pending;
    logic       lx_overflow;
    logic       lx_comments;

    // sender burst shaping and receiver stall pattern
    int         burst_left;
    int         gap_left;
    logic [9:0] rx_tick;
    int         idle_cycles;

    brace_quote_word_splitter #(
        .MAX_BRACE_DEPTH(BRACE_LIMIT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // quoted-string escape decoding
    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            CH_LC_N: return CH_LF;
            CH_LC_R: return CH_CR;
            CH_LC_T: return CH_TAB;
            CH_LC_E: return CH_ESC;
            default: return c;
        endcase
    endfunction

    function automatic t_result byte_item(input logic [7:0] c);
        t_result r;
        r            = '0;
        r.word_byte  = c;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    // closes an unquoted word if one is open
    function automatic logic end_pending_word();
        logic was;
        was        = lx_pending;
        lx_pending = 1'b0;
        return was;
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_SEMI;
    endfunction

    // advance the predicted lexer by one item, queue the word output it causes
    task automatic split_step(input logic [7:0] c, input logic eot);
        t_result res;
        res = '0;
        if (eot) begin
            res.text_done = 1'b1;
            if (lx_overflow) begin
                res.error_code = ERR_OVERFLOW;
            end else if (lx_mode == MODE_ESCAPE || lx_mode == MODE_QUOTE ||
                         lx_mode == MODE_QUOTE_ESC || lx_mode == MODE_BRACE) begin
                res.error_code = ERR_OPEN;
            end else begin
                res.word_end = lx_pending;
            end
            lx_mode     = MODE_NORMAL;
            lx_depth    = 0;
            lx_pending  = 1'b0;
            lx_overflow = 1'b0;
        end else if (!lx_overflow && c != CH_CR) begin
            case (lx_mode)
                MODE_ESCAPE: begin
                    lx_mode = MODE_NORMAL;
                    if (c == CH_LF) begin
                        res.word_end = end_pending_word();
                    end else begin
                        lx_pending = 1'b1;
                        res        = byte_item(c);
                    end
                end
                MODE_QUOTE: begin
                    if (c == CH_DQUOTE && lx_depth == 0) begin
                        lx_mode      = MODE_NORMAL;
                        res.word_end = 1'b1;
                    end else if (c == CH_DQUOTE) begin
                        lx_mode = MODE_BRACE;
                        res     = byte_item(c);
                    end else if (c == CH_BSLASH) begin
                        lx_mode = MODE_QUOTE_ESC;
                    end else begin
                        res = byte_item(c);
                    end
                end
                MODE_QUOTE_ESC: begin
                    lx_mode = MODE_QUOTE;
                    res     = byte_item(unescape(c));
                end
                MODE_BRACE: begin
                    if (c == CH_RBRACE) begin
                        if (lx_depth > 0) lx_depth--;
                        if (lx_depth == 0) begin
                            lx_mode      = MODE_NORMAL;
                            res.word_end = 1'b1;
                        end else begin
                            res = byte_item(c);
                        end
                    end else if (c == CH_LBRACE) begin
                        if (lx_depth >= BRACE_LIMIT) begin
                            lx_overflow = 1'b1;
                        end else begin
                            lx_depth++;
                            res = byte_item(c);
                        end
                    end else begin
                        if (c == CH_DQUOTE) lx_mode = MODE_QUOTE;
                        res = byte_item(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF) lx_mode = MODE_NORMAL;
                end
                default: begin
                    lx_mode = MODE_NORMAL;
                    if (is_separator(c)) begin
                        res.word_end = end_pending_word();
                    end else if (c == CH_DQUOTE) begin
                        lx_mode      = MODE_QUOTE;
                        lx_depth     = 0;
                        res.word_end = end_pending_word();
                    end else if (c == CH_LBRACE) begin
                        lx_mode      = MODE_BRACE;
                        lx_depth     = 1;
                        res.word_end = end_pending_word();
                    end else if (c == CH_BSLASH) begin
                        lx_mode = MODE_ESCAPE;
                    end else if (c == CH_HASH && lx_comments) begin
                        lx_mode      = MODE_COMMENT;
                        res.word_end = end_pending_word();
                    end else begin
                        lx_pending = 1'b1;
                        res        = byte_item(c);
                    end
                end
            endcase
        end
        if (res.byte_valid || res.word_end || res.text_done)
            expected_words = {expected_words, res};
    endtask

    // stimulus building blocks
    task automatic push_byte(input logic [7:0] c);
        t_item it;
        it.text_byte   = c;
        it.end_of_text = 1'b0;
        text_items     = {text_items, it};
        loaded_count++;
    endtask

    task automatic push_end(input logic [7:0] ignored);
        t_item it;
        it.text_byte   = ignored;
        it.end_of_text = 1'b1;
        text_items     = {text_items, it};
        loaded_count++;
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 7))
            0:       return 8'h80 + 8'($urandom_range(0, 127));
            1:       return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] separator();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic [7:0] escape_char();
        case ($urandom_range(0, 5))
            0:       return CH_LC_N;
            1:       return CH_LC_R;
            2:       return CH_LC_T;
            3:       return CH_LC_E;
            4:       return CH_DQUOTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic gen_quoted();
        int n;
        push_byte(CH_DQUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    push_byte(CH_BSLASH);
                    push_byte(escape_char());
                end
                2:       push_byte($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
                3:       push_byte(CH_CR);
                4:       push_byte(separator());
                5:       push_byte(CH_HASH);
                default: push_byte(word_char());
            endcase
        end
        push_byte(CH_DQUOTE);
    endtask

    // braced word, now and then nested close to or past the depth limit
    task automatic gen_braced();
        int depth;
        int limit;
        int steps;
        if ($urandom_range(0, 9) == 0) begin
            limit = $urandom_range(BRACE_LIMIT - 3, BRACE_LIMIT + 2);
            repeat (limit) push_byte(CH_LBRACE);
            depth = limit;
        end else begin
            limit = $urandom_range(1, 4);
            push_byte(CH_LBRACE);
            depth = 1;
        end
        steps = $urandom_range(0, 10);
        repeat (steps) begin
            case ($urandom_range(0, 8))
                0, 1: begin
                    if (depth < limit) begin
                        push_byte(CH_LBRACE);
                        depth++;
                    end
                end
                2: begin
                    if (depth > 1) begin
                        push_byte(CH_RBRACE);
                        depth--;
                    end
                end
                3:       gen_quoted();
                4:       push_byte(CH_CR);
                5:       push_byte(CH_BSLASH);
                6:       push_byte($urandom_range(0, 1) ? separator() : CH_HASH);
                default: push_byte(word_char());
            endcase
        end
        repeat (depth) push_byte(CH_RBRACE);
    endtask

    // one script text of random tokens, ended by an end-of-text item
    task automatic gen_text();
        int first;
        int target;
        int pick;
        first  = loaded_count;
        target = $urandom_range(0, 30);
        while (loaded_count - first < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                repeat ($urandom_range(1, 6)) push_byte(word_char());
                if ($urandom_range(0, 3) != 0) push_byte(separator());
            end else if (pick < 36) begin
                push_byte(separator());
            end else if (pick < 50) begin
                gen_quoted();
            end else if (pick < 64) begin
                gen_braced();
            end else if (pick < 71) begin
                push_byte(CH_BSLASH);
                push_byte(pick < 68 ? 8'($urandom_range(0, 255)) : CH_LF);
            end else if (pick < 79) begin
                push_byte(CH_HASH);
                repeat ($urandom_range(0, 4)) push_byte(word_char());
                if ($urandom_range(0, 3) != 0) push_byte(CH_LF);
            end else if (pick < 84) begin
                push_byte(CH_CR);
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
        // unterminated construct at the end now and then
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
                0: push_byte(CH_BSLASH);
                1: begin
                    push_byte(CH_DQUOTE);
                    push_byte(word_char());
                end
                2: begin
                    push_byte(CH_DQUOTE);
                    push_byte(CH_BSLASH);
                end
                3: begin
                    push_byte(CH_LBRACE);
                    push_byte(word_char());
                end
                default: begin
                    push_byte(CH_LBRACE);
                    push_byte(CH_DQUOTE);
                end
            endcase
        end
        push_end(8'($urandom_range(0, 255)));
    endtask

    // nesting exactly at the limit, or one level past it
    task automatic load_deep_nest(input int levels);
        repeat (levels) push_byte(CH_LBRACE);
        push_byte(word_char());
        push_byte(word_char());
        repeat (levels) push_byte(CH_RBRACE);
        push_end(8'($urandom_range(0, 255)));
    endtask

    task automatic load_directed();
        // comment start closes the word, the comment runs to the newline
        push_byte(8'h61);
        push_byte(8'h62);
        push_byte(CH_HASH);
        push_byte(8'h78);
        push_byte(CH_LF);
        // escape decoded in quotes
        push_byte(CH_DQUOTE);
        push_byte(CH_BSLASH);
        push_byte(CH_LC_E);
        push_byte(CH_DQUOTE);
        // quoted part inside braces keeps its quotes and a literal brace
        push_byte(CH_LBRACE);
        push_byte(CH_DQUOTE);
        push_byte(CH_RBRACE);
        push_byte(CH_DQUOTE);
        push_byte(CH_RBRACE);
        // dropped carriage return, escaped separator, high byte, backslash-newline
        push_byte(CH_CR);
        push_byte(CH_BSLASH);
        push_byte(CH_SEMI);
        push_byte(8'hFF);
        push_byte(CH_BSLASH);
        push_byte(CH_LF);
        // word still open at the end of text
        push_byte(8'h00);
        push_end(8'hFF);
        // brace still open at the end of text
        push_byte(CH_LBRACE);
        push_end(8'h00);
        // trailing comment keeps the word before it
        push_byte(8'h61);
        push_byte(8'h62);
        push_byte(CH_HASH);
        push_end(8'h00);
    endtask

    // wait until nothing is queued, in flight or expected, then let the pipe drain
    task automatic wait_idle();
        @(negedge i_clk);
        while (text_items.size() != 0 || in_if.valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_comments(input logic value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        lx_comments = value;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // text driver: bursts of items with random gaps
    always @(posedge i_clk) begin : drive_text
        t_item nxt;
        logic  taken;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end else begin
            taken = in_if.valid && in_if.ready;
            if (taken) split_step(in_if.text_byte, in_if.end_of_text);
            if (!in_if.valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (text_items.size() > 0) begin
                    nxt = text_items.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.text_byte   <= nxt.text_byte;
                    in_if.end_of_text <= nxt.end_of_text;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // word monitor: stall pattern on ready, compare against predicted words
    always @(posedge i_clk) begin : collect_words
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_tick      = '0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.word_byte  = out_if.word_byte;
                got.byte_valid = out_if.byte_valid;
                got.word_end   = out_if.word_end;
                got.text_done  = out_if.text_done;
                got.error_code = out_if.error_code;
                if (expected_words.size() == 0) begin
                    $display("%0t: word output with none expected, expected nothing actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("word_byte", want.word_byte, got.word_byte);
                    check_field("byte_valid", want.byte_valid, got.byte_valid);
                    check_field("word_end", want.word_end, got.word_end);
                    check_field("text_done", want.text_done, got.text_done);
                    check_field("error_code", want.error_code, got.error_code);
                end
            end
            rx_tick = rx_tick + 1'b1;
            case (rx_tick[9:8])
                2'd0:    out_if.ready <= 1'b1;
                2'd1:    out_if.ready <= ($urandom_range(0, 2) != 0);
                2'd2:    out_if.ready <= (rx_tick[4:2] != 3'd0);
                default: out_if.ready <= (rx_tick[5:3] != 3'd0);
            endcase
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // reset, then phases with a comment setting each
    initial begin : run_phases
        int   ph;
        int   first;
        logic setting;
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = 1'b0;
        in_if.valid       = 1'b0;
        in_if.text_byte   = 8'h00;
        in_if.end_of_text = 1'b0;
        out_if.ready      = 1'b0;
        loaded_count      = 0;
        mismatches        = 0;
        lx_mode           = MODE_NORMAL;
        lx_depth          = 0;
        lx_pending        = 1'b0;
        lx_overflow       = 1'b0;
        lx_comments       = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_idle();
            setting = (ph == PHASE_COUNT - 1) ? 1'($urandom_range(0, 1)) : (ph % 2 == 0);
            write_comments(setting);
            @(negedge i_clk);
            if (ph == 0) load_directed();
            load_deep_nest(BRACE_LIMIT + ph % 2);
            first = loaded_count;
            while (loaded_count - first < RANDOM_PER_PHASE) gen_text();
        end
        wait_idle();

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
